>>> src/cdp_pkg.sv
// Shared constants, types and helpers for the complex dot-product core.
// No dependencies; imported by every module of the block.
package cdp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TERM_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 2;

    typedef logic [APB_AW-1:0] apb_addr_t;

    // register map (byte addresses)
    localparam apb_addr_t ADDR_TERM_SHIFT = 2'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic [SHIFT_W-1:0]         shift_t;

    // Clamp a 32-bit two's complement value to the int16 range.
    function automatic sample_t sat16(input term_t v);
        logic all_zero;
        logic all_ones;
        sample_t r;
        all_zero = (v[TERM_W-1:SAMPLE_W-1] == '0);
        all_ones = (v[TERM_W-1:SAMPLE_W-1] == '1);
        if (all_zero || all_ones)
        begin
            r = v[SAMPLE_W-1:0];
        end
        else if (v[TERM_W-1])
        begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> src/complex_dot_product_q15_core.sv
// Top level: accumulates conj(x)*y over a vector, emits saturated int16 on last.
// Depends on cdp_pkg and cdp_apb.
//
//  channel | direction | handshake                 | word
//  item    | in        | item_valid / item_stall   | x_re, x_im, y_re, y_im, last
//  result  | out       | result_valid/result_stall | result_re, result_im
//  config  | in        | APB psel/penable/pready   | term_shift at byte 0
//
// One word is taken every cycle while item_stall is low. A last word passes the
// input register, product register and term register, then accumulates into the
// output register, where its result shows. Reset clears the accumulators and term_shift.
// A held result only stalls the input once a further last word reaches the
// term register and the stages behind it are full.
module complex_dot_product_q15_core
    import cdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  sample_t           x_re,
    input  sample_t           x_im,
    input  sample_t           y_re,
    input  sample_t           y_im,
    input  logic              last,
    output logic              result_valid,
    input  logic              result_stall,
    output sample_t           result_re,
    output sample_t           result_im,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  apb_addr_t         paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    shift_t term_shift;

    // stage 1: input register
    logic    v1_reg;
    sample_t xr1_reg, xi1_reg, yr1_reg, yi1_reg;
    logic    last1_reg;
    // stage 2: products
    logic    v2_reg;
    term_t   prr_reg, pii_reg, pri_reg, pin_reg;
    logic    last2_reg;
    // stage 3: shifted terms
    logic    v3_reg;
    term_t   tre_reg, tim_reg;
    logic    last3_reg;
    // accumulators and result
    term_t   acc_re_reg, acc_im_reg;
    term_t   acc_re_next, acc_im_next;
    logic    out_valid_reg;
    sample_t res_re_reg, res_im_reg;

    sample_t nyr;
    term_t   p_rr, p_ii, p_ri, p_in;
    term_t   sum_re, sum_im;
    logic    consume3, ready3, ready2, ready1;

    cdp_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .term_shift (term_shift)
    );

    // a last word may only leave stage 3 when the output register is free
    assign consume3   = v3_reg && (!last3_reg || !out_valid_reg || !result_stall);
    assign ready3     = !v3_reg || consume3;
    assign ready2     = !v2_reg || ready3;
    assign ready1     = !v1_reg || ready2;
    assign item_stall = !ready1;

    // 16-bit negate wraps -32768 onto itself
    assign nyr  = ~yr1_reg + sample_t'(1);
    assign p_rr = xr1_reg * yr1_reg;
    assign p_ii = xi1_reg * yi1_reg;
    assign p_ri = xr1_reg * yi1_reg;
    assign p_in = xi1_reg * nyr;

    assign sum_re = prr_reg + pii_reg;
    assign sum_im = pri_reg + pin_reg;

    assign acc_re_next = acc_re_reg + tre_reg;
    assign acc_im_next = acc_im_reg + tim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= item_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && item_valid)
        begin
            xr1_reg   <= x_re;
            xi1_reg   <= x_im;
            yr1_reg   <= y_re;
            yi1_reg   <= y_im;
            last1_reg <= last;
        end
        if (ready2 && v1_reg)
        begin
            prr_reg   <= p_rr;
            pii_reg   <= p_ii;
            pri_reg   <= p_ri;
            pin_reg   <= p_in;
            last2_reg <= last1_reg;
        end
        if (ready3 && v2_reg)
        begin
            tre_reg   <= sum_re >>> term_shift;
            tim_reg   <= sum_im >>> term_shift;
            last3_reg <= last2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (consume3 && last3_reg)
            begin
                acc_re_reg    <= '0;
                acc_im_reg    <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (consume3)
                begin
                    acc_re_reg <= acc_re_next;
                    acc_im_reg <= acc_im_next;
                end
                if (!result_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume3 && last3_reg)
        begin
            res_re_reg <= sat16(acc_re_next);
            res_im_reg <= sat16(acc_im_next);
        end
    end

    assign result_valid = out_valid_reg;
    assign result_re    = res_re_reg;
    assign result_im    = res_im_reg;

endmodule

>>> src/cdp_apb.sv
// APB register file for the complex dot-product core: holds term_shift.
// Depends on cdp_pkg.
module cdp_apb
    import cdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  apb_addr_t         paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output shift_t            term_shift
);

    shift_t term_shift_reg;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TERM_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_shift_reg <= '0;
        end
        else if (wr_en)
        begin
            term_shift_reg <= pwdata[SHIFT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_TERM_SHIFT: prdata = {{(APB_DW-SHIFT_W){1'b0}}, term_shift_reg};
            default:         prdata = '0;
        endcase
    end

    assign term_shift = term_shift_reg;

endmodule

>>> src/cdp_checker.sv
// Port-level checks for the complex dot-product core, bound to the top level.
// Depends on cdp_pkg.
module cdp_checker
    import cdp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input sample_t           result_re,
    input sample_t           result_im,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input apb_addr_t         paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    // a held result word stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_re) && $stable(result_im))
    else $error("result word changed while stalled");

    // input only backs up behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

    // term_shift reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr == ADDR_TERM_SHIFT)
        |=> (paddr != ADDR_TERM_SHIFT) ||
            (prdata == {{(APB_DW-SHIFT_W){1'b0}}, $past(pwdata[SHIFT_W-1:0])}))
    else $error("term_shift readback mismatch");

endmodule

bind complex_dot_product_q15_core cdp_checker u_cdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_re    (result_re),
    .result_im    (result_im),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

>>> dv/complex_dot_product_q15_core_tb.sv
// Self-checking bench for complex_dot_product_q15_core: predicts each saturated conj(x)*y sum
// and checks every result word against it. Depends on cdp_pkg and the core's RTL only.
`timescale 1ns / 100ps

module complex_dot_product_q15_core_tb;
    import cdp_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 6;
    localparam int HANG_LIMIT   = 4000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 170;

    typedef struct packed {
        sample_t xr;
        sample_t xi;
        sample_t yr;
        sample_t yi;
        logic    last;
    } pair_word_t;

    typedef struct packed {
        sample_t re;
        sample_t im;
    } dot_sum_t;

    class dot_product_checker;
        shift_t   term_shift;
        term_t    acc_re;
        term_t    acc_im;
        dot_sum_t pending_sums[$];
        int       errors;

        function new();
            term_shift = '0;
            acc_re     = '0;
            acc_im     = '0;
            errors     = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_MAX)
            begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function sample_t clamp16(term_t v);
            if (v > 32767)
            begin
                return 16'sh7fff;
            end
            if (v < -32768)
            begin
                return 16'sh8000;
            end
            return sample_t'(v);
        endfunction

        // conj(x)*y into the running sums; a last word closes the vector
        function void take_pair(pair_word_t w);
            sample_t neg_yr;
            term_t   re_t;
            term_t   im_t;
            neg_yr = -w.yr;   // -(-32768) wraps back to -32768
            re_t = term_t'(w.xr) * term_t'(w.yr) + term_t'(w.xi) * term_t'(w.yi);
            im_t = term_t'(w.xr) * term_t'(w.yi) + term_t'(w.xi) * term_t'(neg_yr);
            acc_re += re_t >>> term_shift;
            acc_im += im_t >>> term_shift;
            if (w.last)
            begin
                pending_sums.push_back('{re: clamp16(acc_re), im: clamp16(acc_im)});
                acc_re = '0;
                acc_im = '0;
            end
        endfunction

        function void check_sum(sample_t re, sample_t im);
            dot_sum_t exp_sum;
            if (pending_sums.size() == 0)
            begin
                flag($sformatf("unexpected result re=%0d im=%0d", re, im));
                return;
            end
            exp_sum = pending_sums.pop_front();
            if (re !== exp_sum.re)
            begin
                flag($sformatf("result_re expected %0d got %0d", exp_sum.re, re));
            end
            if (im !== exp_sum.im)
            begin
                flag($sformatf("result_im expected %0d got %0d", exp_sum.im, im));
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    sample_t           x_re         = '0;
    sample_t           x_im         = '0;
    sample_t           y_re         = '0;
    sample_t           y_im         = '0;
    logic              last         = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    sample_t           result_re;
    sample_t           result_im;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    apb_addr_t         paddr        = ADDR_TERM_SHIFT;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dot_product_checker sums = new();
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;

    complex_dot_product_q15_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .x_re         (x_re),
        .x_im         (x_im),
        .y_re         (y_re),
        .y_im         (y_im),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_re    (result_re),
        .result_im    (result_im),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sums.check_sum(result_re, result_im);
        end
    end

    // hang detector: cycles in which no word and no register access moves
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic pair_word_t make_pair(int xr, int xi, int yr, int yi, bit is_last);
        pair_word_t w;
        w.xr   = sample_t'(xr);
        w.xi   = sample_t'(xi);
        w.yr   = sample_t'(yr);
        w.yi   = sample_t'(yi);
        w.last = is_last;
        return w;
    endfunction

    function automatic sample_t pick_sample();
        int corners[5] = '{-32768, 32767, 0, -1, 1};
        case ($urandom_range(7))
            0:       return sample_t'(corners[$urandom_range(4)]);
            1, 2, 3: return sample_t'($urandom);
            default: return sample_t'(int'($urandom_range(511)) - 256);
        endcase
    endfunction

    task automatic send_pair(input pair_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            {x_re, x_im, y_re, y_im, last} <= {$urandom, $urandom, 1'($urandom)};
            @(posedge clk);
        end
        item_valid <= 1'b1;
        x_re       <= w.xr;
        x_im       <= w.xi;
        y_re       <= w.yr;
        y_im       <= w.yi;
        last       <= w.last;
        do
            @(posedge clk);
        while (item_stall);
        sums.take_pair(w);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sums.pending_sums.size() != 0);
    endtask

    // write then read back; the shift only takes effect in the predictor once written
    task automatic set_term_shift(input shift_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TERM_SHIFT;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sums.term_shift = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DW'(value))
        begin
            sums.flag($sformatf("term_shift read expected %0d got %0d", value, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_directed();
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1));
        send_pair(make_pair(32767, 32767, 32767, 32767, 1));
        send_pair(make_pair(0, 0, 0, 0, 1));
        send_pair(make_pair(0, 1, -32768, 0, 1));       // negated y_re wraps
        send_pair(make_pair(1, 0, -32768, 5, 1));
        send_pair(make_pair(32767, -32768, -32768, 32767, 1));
        send_pair(make_pair(-32768, 32767, 32767, -32768, 1));
        send_pair(make_pair(-1, -1, -1, 1, 1));
        // two near-full terms wrap the accumulator negative
        send_pair(make_pair(32767, 32767, 32767, 32767, 0));
        send_pair(make_pair(32767, 32767, 32767, 32767, 1));
        send_pair(make_pair(-32768, -32768, -32768, -32768, 0));
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1));
        send_pair(make_pair(3, -2, 7, 4, 0));
        send_pair(make_pair(-5, 6, -1, 2, 0));
        send_pair(make_pair(100, -100, 50, 25, 1));
        send_pair(make_pair(200, 300, -400, 500, 1));
    endtask

    task automatic send_vectors(input int n_words);
        int sent;
        int len;
        bit paused;
        pair_word_t w;
        sent   = 0;
        paused = 0;
        while (sent < n_words)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                w.xr   = pick_sample();
                w.xi   = pick_sample();
                w.yr   = pick_sample();
                w.yi   = pick_sample();
                w.last = (k == len - 1);
                send_pair(w);
            end
            sent += len;
            if (!paused && sent >= n_words / 2)
            begin
                drain();
                paused = 1;
            end
        end
    endtask

    initial
    begin
        shift_t phase_shift;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 64; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            if (phase == 0)
            begin
                send_directed();
            end
            else
            begin
                case (phase)
                    1:       phase_shift = 5'd31;
                    2:       phase_shift = 5'd15;
                    3:       phase_shift = 5'd1;
                    4:       phase_shift = shift_t'($urandom_range(2, 30));
                    default: phase_shift = 5'd0;
                endcase
                // vectors are closed and drained before touching the shift
                drain();
                repeat (SETTLE) @(posedge clk);
                set_term_shift(phase_shift);
            end
            send_vectors(PHASE_WORDS);
        end
        drain();
        repeat (SETTLE) @(posedge clk);
        if (sums.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
